// ===== design/fixed_point_alu_core_macros.svh =====
// assertion macros for the fixed-point alu checker
// no dependencies; taken in by the checker file
`ifndef FIXED_POINT_ALU_CORE_MACROS_SVH
`define FIXED_POINT_ALU_CORE_MACROS_SVH

// clocked property, switched off while reset is asserted
`define FPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must hold whenever the strobe marks a result
`define FPA_ASSERT_ON_STROBE(lbl, clk, rst_n, strb, cond, msg) \
    `FPA_ASSERT(lbl, clk, rst_n, ((strb) |-> (cond)), msg)

`endif

// ===== design/fpa_pkg.sv =====
// shared types, action codes and saturation helper of the fixed-point alu
// no dependencies; used by the top level, fpa_mul and fpa_checker
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    // action codes
    typedef enum logic [3:0] {
        ACT_ADD      = 4'd0,
        ACT_SUB      = 4'd1,
        ACT_MUL      = 4'd2,
        ACT_DIV      = 4'd3,
        ACT_GT       = 4'd4,
        ACT_LT       = 4'd5,
        ACT_GE       = 4'd6,
        ACT_LE       = 4'd7,
        ACT_EQ       = 4'd8,
        ACT_NE       = 4'd9,
        ACT_INC      = 4'd10,
        ACT_DEC      = 4'd11,
        ACT_MIN      = 4'd12,
        ACT_MAX      = 4'd13,
        ACT_FROM_INT = 4'd14,
        ACT_TO_INT   = 4'd15
    } t_fpa_action;

    // input item
    typedef struct packed {
        t_fpa_action        action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_fpa_in;

    // result item
    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               overflow;
        logic               divide_by_zero;
    } t_fpa_out;

    // saturated 32-bit value with its overflow flag
    typedef struct packed {
        logic               ov;
        logic signed [31:0] value;
    } t_fpa_sat;

    // per-item side information carried alongside the divider
    typedef struct packed {
        t_fpa_action action;
        t_fpa_out    simple;
    } t_fpa_side;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    // clamp a wide signed value into 32 bits
    function automatic t_fpa_sat fpa_saturate(input logic signed [63:0] v);
        t_fpa_sat s;
        if (v > SAT_MAX) begin
            s.ov    = 1'b1;
            s.value = SAT_MAX[31:0];
        end else if (v < SAT_MIN) begin
            s.ov    = 1'b1;
            s.value = SAT_MIN[31:0];
        end else begin
            s.ov    = 1'b0;
            s.value = v[31:0];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== design/fixed_point_alu_core.sv =====
// fixed-point alu: Q(32-FRACTION_BITS).FRACTION_BITS add/sub/mul/div/compare
// top level; depends on fpa_pkg, fpa_mul, fpa_divider and fpa_delay
// Every action passes through the front stage registers, a path as deep as
// the divider with its rounding register, and the output register before its
// result strobe, and one item can be started in every cycle; o_busy stays
// low. The divider produces one quotient bit per pipeline stage over
// 32 + FRACTION_BITS stages; all other actions travel alongside it so results
// leave in start order. Each result shows for exactly one cycle with o_strobe
// and must be taken then, as the block has no way to hold it.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu_core #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fpa_pkg::t_fpa_in  i_item,
    output logic              o_busy,
    output logic              o_strobe,
    output fpa_pkg::t_fpa_out o_result
);

    localparam int DIV_STAGES = 32 + FRACTION_BITS;

    logic w_busy;
    logic w_accept;

    // front stage signals
    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic signed [63:0] w_a64;
    logic signed [63:0] w_b64;
    fpa_pkg::t_fpa_sat  w_sat;
    fpa_pkg::t_fpa_side n_side;

    fpa_pkg::t_fpa_side r_side;
    logic [31:0]        r_mag_a;
    logic [31:0]        r_mag_b;
    logic               r_neg;

    // valid bits, index 0 lines up with the front stage registers
    logic [DIV_STAGES+1:0] r_vld;

    // aligned results
    fpa_pkg::t_fpa_side          w_side_d;
    fpa_pkg::t_fpa_sat           w_mul_res;
    fpa_pkg::t_fpa_sat           w_mul_d;
    logic [DIV_STAGES-1:0]       w_quo;
    logic [31:0]                 w_rem;
    logic [31:0]                 w_den;
    logic                        w_div_neg;
    logic                        w_round_up;
    logic [63:0]                 w_div_mag;
    logic signed [63:0]          w_div_signed;
    fpa_pkg::t_fpa_sat           r_div_res;
    fpa_pkg::t_fpa_out           n_out;
    fpa_pkg::t_fpa_out           r_out;
    logic                        r_out_vld;

    // no back-pressure anywhere in the pipeline
    assign w_busy   = 1'b0;
    assign w_accept = i_start & ~w_busy;
    assign o_busy   = w_busy;

    // front stage: single-cycle actions and operand magnitudes
    always_comb begin
        w_a    = i_item.operand_a;
        w_b    = i_item.operand_b;
        w_a64  = {{32{w_a[31]}}, w_a};
        w_b64  = {{32{w_b[31]}}, w_b};
        w_sat  = '0;
        n_side = '0;
        n_side.action = i_item.action;
        case (i_item.action)
            fpa_pkg::ACT_ADD: begin
                w_sat = fpa_pkg::fpa_saturate(w_a64 + w_b64);
            end
            fpa_pkg::ACT_SUB: begin
                w_sat = fpa_pkg::fpa_saturate(w_a64 - w_b64);
            end
            fpa_pkg::ACT_INC: begin
                w_sat = fpa_pkg::fpa_saturate(w_a64 + 64'sd1);
            end
            fpa_pkg::ACT_DEC: begin
                w_sat = fpa_pkg::fpa_saturate(w_a64 - 64'sd1);
            end
            fpa_pkg::ACT_FROM_INT: begin
                w_sat = fpa_pkg::fpa_saturate(w_a64 <<< FRACTION_BITS);
            end
            fpa_pkg::ACT_TO_INT: begin
                w_sat.value = w_a >>> FRACTION_BITS;
            end
            fpa_pkg::ACT_MIN: begin
                w_sat.value = (w_a < w_b) ? w_a : w_b;
            end
            fpa_pkg::ACT_MAX: begin
                w_sat.value = (w_a > w_b) ? w_a : w_b;
            end
            fpa_pkg::ACT_GT: begin
                n_side.simple.compare_true = w_a > w_b;
            end
            fpa_pkg::ACT_LT: begin
                n_side.simple.compare_true = w_a < w_b;
            end
            fpa_pkg::ACT_GE: begin
                n_side.simple.compare_true = w_a >= w_b;
            end
            fpa_pkg::ACT_LE: begin
                n_side.simple.compare_true = w_a <= w_b;
            end
            fpa_pkg::ACT_EQ: begin
                n_side.simple.compare_true = w_a == w_b;
            end
            fpa_pkg::ACT_NE: begin
                n_side.simple.compare_true = w_a != w_b;
            end
            fpa_pkg::ACT_DIV: begin
                n_side.simple.divide_by_zero = w_b == 32'sd0;
            end
            default: begin
                // multiply is finished in its own unit
                w_sat = '0;
            end
        endcase
        n_side.simple.result_value = w_sat.value;
        n_side.simple.overflow     = w_sat.ov;
    end

    // front stage registers
    always_ff @(posedge i_clk) begin
        r_side  <= n_side;
        r_mag_a <= w_a[31] ? 32'(-w_a) : 32'(w_a);
        r_mag_b <= w_b[31] ? 32'(-w_b) : 32'(w_b);
        r_neg   <= w_a[31] ^ w_b[31];
    end

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[DIV_STAGES:0], w_accept};
            r_out_vld <= r_vld[DIV_STAGES+1];
        end
    end

    // multiply path, then wait for the divider
    fpa_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_mag_a (r_mag_a),
        .i_mag_b (r_mag_b),
        .i_neg   (r_neg),
        .o_res   (w_mul_res)
    );

    fpa_delay #(
        .WIDTH($bits(fpa_pkg::t_fpa_sat)),
        .DEPTH(DIV_STAGES - 1)
    ) u_mul_dly (
        .i_clk (i_clk),
        .i_d   (w_mul_res),
        .o_q   (w_mul_d)
    );

    // divide path
    fpa_divider #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk (i_clk),
        .i_num (r_mag_a),
        .i_den (r_mag_b),
        .o_quo (w_quo),
        .o_rem (w_rem),
        .o_den (w_den)
    );

    fpa_delay #(
        .WIDTH(1),
        .DEPTH(DIV_STAGES)
    ) u_neg_dly (
        .i_clk (i_clk),
        .i_d   (r_neg),
        .o_q   (w_div_neg)
    );

    // round half away from zero: bump when twice the remainder reaches the divisor
    always_comb begin
        w_round_up   = {w_rem, 1'b0} >= {1'b0, w_den};
        w_div_mag    = 64'(w_quo) + 64'(w_round_up);
        w_div_signed = w_div_neg ? -$signed(w_div_mag) : $signed(w_div_mag);
    end

    always_ff @(posedge i_clk) begin
        r_div_res <= fpa_pkg::fpa_saturate(w_div_signed);
    end

    // side information follows the divider
    fpa_delay #(
        .WIDTH($bits(fpa_pkg::t_fpa_side)),
        .DEPTH(DIV_STAGES + 1)
    ) u_side_dly (
        .i_clk (i_clk),
        .i_d   (r_side),
        .o_q   (w_side_d)
    );

    // final select
    always_comb begin
        n_out = w_side_d.simple;
        case (w_side_d.action)
            fpa_pkg::ACT_MUL: begin
                n_out              = '0;
                n_out.result_value = w_mul_d.value;
                n_out.overflow     = w_mul_d.ov;
            end
            fpa_pkg::ACT_DIV: begin
                if (!w_side_d.simple.divide_by_zero) begin
                    n_out              = '0;
                    n_out.result_value = r_div_res.value;
                    n_out.overflow     = r_div_res.ov;
                end
            end
            default: begin
                n_out = w_side_d.simple;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== design/fpa_delay.sv =====
// fixed-length delay line for side information and results of the fixed-point alu
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fpa_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    // shift one place per cycle
    always_ff @(posedge i_clk) begin
        r_pipe[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_pipe[i] <= r_pipe[i-1];
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

`default_nettype wire

// ===== design/fpa_div_step.sv =====
// one restoring-division stage: one quotient bit per stage, registered
// no dependencies; instantiated by fpa_divider
`timescale 1ns / 1ps
`default_nettype none

module fpa_div_step #(
    parameter int QW = 40
) (
    input  logic          i_clk,
    input  logic [31:0]   i_rem,
    input  logic [QW-1:0] i_nq,
    input  logic [31:0]   i_den,
    output logic [31:0]   o_rem,
    output logic [QW-1:0] o_nq,
    output logic [31:0]   o_den
);

    logic [32:0] w_trial;
    logic [32:0] w_diff;
    logic        w_ge;
    logic [31:0] n_rem;
    logic [QW-1:0] n_nq;

    // bring down the next numerator bit and try the subtract
    always_comb begin
        w_trial = {i_rem, i_nq[QW-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_ge    = w_trial >= {1'b0, i_den};
        n_rem   = w_ge ? w_diff[31:0] : w_trial[31:0];
        // numerator bits leave at the top, quotient bits enter at the bottom
        n_nq    = {i_nq[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        o_rem <= n_rem;
        o_nq  <= n_nq;
        o_den <= i_den;
    end

endmodule

`default_nettype wire

// ===== design/fpa_divider.sv =====
// pipelined unsigned divider: (num << FRACTION_BITS) / den, floor and remainder
// depends on fpa_div_step
`timescale 1ns / 1ps
`default_nettype none

module fpa_divider #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                        i_clk,
    input  logic [31:0]                 i_num,
    input  logic [31:0]                 i_den,
    output logic [32+FRACTION_BITS-1:0] o_quo,
    output logic [31:0]                 o_rem,
    output logic [31:0]                 o_den
);

    localparam int QW = 32 + FRACTION_BITS;

    logic [31:0]   w_rem [QW+1];
    logic [QW-1:0] w_nq  [QW+1];
    logic [31:0]   w_den [QW+1];

    // scaled numerator enters with an empty remainder
    assign w_rem[0] = '0;
    assign w_nq[0]  = {i_num, {FRACTION_BITS{1'b0}}};
    assign w_den[0] = i_den;

    for (genvar g = 0; g < QW; g++) begin : g_step
        fpa_div_step #(
            .QW(QW)
        ) u_step (
            .i_clk (i_clk),
            .i_rem (w_rem[g]),
            .i_nq  (w_nq[g]),
            .i_den (w_den[g]),
            .o_rem (w_rem[g+1]),
            .o_nq  (w_nq[g+1]),
            .o_den (w_den[g+1])
        );
    end

    assign o_quo = w_nq[QW];
    assign o_rem = w_rem[QW];
    assign o_den = w_den[QW];

endmodule

`default_nettype wire

// ===== design/fpa_mul.sv =====
// two-stage fixed-point multiply: product, then round half away and saturate
// depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpa_mul #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              i_clk,
    input  logic [31:0]       i_mag_a,
    input  logic [31:0]       i_mag_b,
    input  logic              i_neg,
    output fpa_pkg::t_fpa_sat o_res
);

    localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

    logic [63:0]        r_prod;
    logic               r_neg;
    logic [63:0]        w_prod;
    logic [63:0]        w_round;
    logic signed [63:0] w_signed;

    // magnitude product
    assign w_prod = {32'd0, i_mag_a} * {32'd0, i_mag_b};

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_neg  <= i_neg;
    end

    // round to nearest on the magnitude, then restore the sign
    always_comb begin
        w_round  = (r_prod + HALF) >> FRACTION_BITS;
        w_signed = r_neg ? -$signed(w_round) : $signed(w_round);
    end

    always_ff @(posedge i_clk) begin
        o_res <= fpa_pkg::fpa_saturate(w_signed);
    end

endmodule

`default_nettype wire

// ===== design/fpa_checker.sv =====
// port-level checks of the fixed-point alu, bound to its top level
// depends on fpa_pkg and fixed_point_alu_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_alu_core_macros.svh"

module fpa_checker #(
    parameter int FRACTION_BITS = 8
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_start,
    input wire logic              o_busy,
    input wire logic              o_strobe,
    input wire fpa_pkg::t_fpa_out o_result
);

    localparam int LATENCY = FRACTION_BITS + 35;

    // a zero divisor gives a clean zero result
    `FPA_ASSERT_ON_STROBE(a_dz_clean, i_clk, i_rst_n, o_strobe && o_result.divide_by_zero, (o_result.result_value == 32'sd0 && !o_result.overflow && !o_result.compare_true), "divide by zero result not clean")

    // comparisons return only the flag
    `FPA_ASSERT_ON_STROBE(a_cmp_clean, i_clk, i_rst_n, o_strobe && o_result.compare_true, (o_result.result_value == 32'sd0 && !o_result.overflow && !o_result.divide_by_zero), "comparison result carries a value")

    // a saturated result sits on one of the rails
    `FPA_ASSERT_ON_STROBE(a_ov_rail, i_clk, i_rst_n, o_strobe && o_result.overflow, (o_result.result_value == 32'sh7FFF_FFFF || o_result.result_value == 32'sh8000_0000), "overflow without saturated value")

    // each result traces back to a started item a fixed latency earlier
    `FPA_ASSERT_ON_STROBE(a_strobe_src, i_clk, i_rst_n, o_strobe, $past(i_start && !o_busy, LATENCY), "result without a started item")

endmodule

bind fixed_point_alu_core fpa_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_fpa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
